>>> src/ptba_pkg.sv
// ----------------------------------------------------------------------------
// ptba_pkg
// Shared types and constants for the per-task bandwidth accounting core.
// ----------------------------------------------------------------------------
package ptba_pkg;

   localparam int TableSlotsDefault = 16;

   localparam logic [1:0] REQ_TICK0  = 2'd0;
   localparam logic [1:0] REQ_TICK1  = 2'd1;
   localparam logic [1:0] REQ_REPORT = 2'd2;

   localparam logic [1:0] CSR_TICK_RATE = 2'd0;
   localparam logic [1:0] CSR_LINE      = 2'd1;
   localparam logic [1:0] CSR_DMA       = 2'd2;

   localparam logic [16:0] TickRateReset = 17'd1000;
   localparam logic [12:0] LineReset     = 13'd128;
   localparam logic [31:0] DmaReset      = 32'd165888000;

   // Datapath operations.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_TICK_LOAD,    // capture request, start search
      OP_SEARCH,       // compare one slot
      OP_TICK_APPLY,   // add delta to chosen slot
      OP_REP_SUM,      // read/clear one slot, add to sum
      OP_BW_START,     // start bandwidth division for current operand
      OP_BW_FINISH,    // store total: sum bandwidth plus DMA, saturated
      OP_PCT_START,    // start percent division
      OP_EMIT,         // load output register
      OP_SLOT_LOAD     // load the captured misses of the current slot
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       sel_total;   // bandwidth operand is the sum, not a slot
      logic       rst_slot;    // reset slot pointer
      logic       nxt_slot;    // advance slot pointer
   } cmd_type;

   typedef struct packed {
      logic       found;       // search hit
      logic       search_end;  // pointer reached slots_used
      logic       slot_last;   // pointer is last used slot
      logic       have_slots;
      logic       ticks_zero;
      logic       div_done;
   } sts_type;

endpackage

>>> src/ptba_div.sv
// ----------------------------------------------------------------------------
// ptba_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptba_div #(
   parameter int NW = 64,
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [NW-1:0] quot,
   output logic [DW-1:0] rem
);
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] q_ff, q_in;
   logic [DW-1:0] r_ff, r_in;
   logic [DW-1:0] d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [DW:0]   trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff, q_ff[NW-1]};
      if (start) begin
         q_in = num; r_in = '0; d_in = den; cnt_in = CW'(NW); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = DW'(trial - {1'b0, d_ff});
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = trial[DW-1:0];
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign rem  = r_ff;
endmodule

>>> src/ptba_datapath.sv
// ----------------------------------------------------------------------------
// ptba_datapath
// Slot table, counters and the bandwidth arithmetic.
// ----------------------------------------------------------------------------
module ptba_datapath #(
   parameter int TABLE_SLOTS = ptba_pkg::TableSlotsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  ptba_pkg::cmd_type  cmd,
   output ptba_pkg::sts_type  sts,
   input  logic [1:0]         req_type,
   input  logic [15:0]        task_id,
   input  logic [31:0]        counter_value,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   output logic [3:0]         o_index,
   output logic [15:0]        o_task,
   output logic [31:0]        o_miss,
   output logic [31:0]        o_bw,
   output logic [6:0]         o_pct,
   output logic [31:0]        o_total
);
   localparam int SW = $clog2(TABLE_SLOTS + 1);
   localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

   logic [16:0] rate_ff;
   logic [12:0] line_ff;
   logic [31:0] dma_ff;
   logic [31:0] last_ff [2];
   logic [15:0] owner_ff [TABLE_SLOTS];
   logic [31:0] miss_ff [TABLE_SLOTS];
   logic [SW-1:0] used_ff;
   logic [31:0] ticks_ff, rticks_ff;
   logic [SW-1:0] ptr_ff;
   logic        cpu_ff;
   logic [15:0] task_ff;
   logic [31:0] delta_ff;
   logic [SW-1:0] count_ff;
   logic        found_ff;
   logic [SW-1:0] hit_ff;
   logic [36:0] sum_ff;
   logic [31:0] cur_miss_ff;
   logic [31:0] bw_ff, total_ff;
   logic [IW-1:0] pidx;
   // Bandwidth division: stage 0 num/ticks, stage 1 r*rate/ticks.
   logic [1:0]  dstage_ff;
   logic [31:0] q_hi_ff;
   logic        q_ovf_ff;
   logic        div_start;
   logic [63:0] div_num;
   logic [31:0] div_den;
   logic        div_done;
   logic [63:0] div_q;
   logic [31:0] div_r;
   logic        bw_zero;
   logic [49:0] m_line;
   logic [48:0] res_sum;
   // Per-slot captured misses for the report pass.
   logic [31:0] snap_ff [TABLE_SLOTS];

   assign pidx = ptr_ff[IW-1:0];
   // ticks * 100 as ticks * 64 + ticks * 32 + ticks * 4.
   assign bw_zero = ({1'b0, rticks_ff, 6'd0} + {2'd0, rticks_ff, 5'd0}
                     + {5'd0, rticks_ff, 2'd0}) <= 39'(rate_ff);
   assign m_line = (cmd.sel_total ? sum_ff : {5'd0, cur_miss_ff}) * line_ff;

   ptba_div #(.NW(64), .DW(32)) u_div (
      .clock, .reset, .start(div_start), .num(div_num), .den(div_den),
      .done(div_done), .quot(div_q), .rem(div_r));

   always_comb begin
      div_start = 1'b0;
      div_num = '0;
      div_den = rticks_ff;
      if (cmd.op == ptba_pkg::OP_BW_START && !bw_zero) begin
         div_start = 1'b1; div_num = 64'(m_line);
      end else if (div_done && dstage_ff == 2'd0) begin
         div_start = 1'b1; div_num = 64'(div_r * rate_ff);
      end else if (cmd.op == ptba_pkg::OP_PCT_START && total_ff != 32'd0) begin
         div_start = 1'b1; div_num = 64'(bw_ff * 7'd100); div_den = total_ff;
      end
   end

   assign res_sum = 49'(q_hi_ff * rate_ff) + 49'(div_q[31:0]);

   always_comb begin
      sts.found      = found_ff;
      sts.search_end = (ptr_ff >= count_ff);
      sts.slot_last  = (ptr_ff + 1'b1 == count_ff);
      sts.have_slots = (count_ff != '0);
      sts.ticks_zero = (rticks_ff == 32'd0);
      sts.div_done   = (div_done && dstage_ff != 2'd0) || dstage_ff == 2'd3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= ptba_pkg::TickRateReset;
         line_ff <= ptba_pkg::LineReset;
         dma_ff  <= ptba_pkg::DmaReset;
         last_ff[0] <= '0; last_ff[1] <= '0;
         for (int i = 0; i < TABLE_SLOTS; i++) miss_ff[i] <= '0;
         used_ff <= '0; ticks_ff <= '0; ptr_ff <= '0; found_ff <= 1'b0;
         dstage_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               ptba_pkg::CSR_TICK_RATE: rate_ff <= csr_wdata[16:0];
               ptba_pkg::CSR_LINE:      line_ff <= csr_wdata[12:0];
               ptba_pkg::CSR_DMA:       dma_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.rst_slot) ptr_ff <= '0;
         else if (cmd.nxt_slot) ptr_ff <= ptr_ff + 1'b1;
         case (cmd.op)
            ptba_pkg::OP_TICK_LOAD: begin
               cpu_ff   <= req_type[0];
               task_ff  <= task_id;
               delta_ff <= counter_value - last_ff[req_type[0]];
               if (req_type != ptba_pkg::REQ_REPORT) last_ff[req_type[0]] <= counter_value;
               count_ff <= used_ff;
               rticks_ff <= ticks_ff;
               found_ff <= 1'b0;
               sum_ff   <= '0;
               if (req_type == ptba_pkg::REQ_REPORT) ticks_ff <= '0;
            end
            ptba_pkg::OP_SEARCH: begin
               if (owner_ff[pidx] == task_ff) begin
                  found_ff <= 1'b1; hit_ff <= ptr_ff;
               end
            end
            ptba_pkg::OP_TICK_APPLY: begin
               if (found_ff) miss_ff[hit_ff[IW-1:0]] <= miss_ff[hit_ff[IW-1:0]] + delta_ff;
               else if (used_ff < SW'(TABLE_SLOTS)) begin
                  owner_ff[used_ff[IW-1:0]] <= task_ff;
                  miss_ff[used_ff[IW-1:0]]  <= delta_ff;
                  used_ff <= used_ff + 1'b1;
               end
               if (!cpu_ff) ticks_ff <= ticks_ff + 1'b1;
            end
            ptba_pkg::OP_REP_SUM: begin
               sum_ff <= sum_ff + 37'(miss_ff[pidx]);
               miss_ff[pidx] <= '0;
               // Keep the captured counts in the owner-parallel shadow.
            end
            default: ;
         endcase
         // Bandwidth division sequencing.
         if (cmd.op == ptba_pkg::OP_BW_START) begin
            dstage_ff <= bw_zero ? 2'd3 : 2'd0;
            if (bw_zero) bw_ff <= '0;
         end else if (div_done && dstage_ff == 2'd0) begin
            q_hi_ff  <= div_q[31:0];
            q_ovf_ff <= div_q[63:32] != 32'd0;
            dstage_ff <= 2'd1;
         end else if (div_done && dstage_ff == 2'd1) begin
            bw_ff <= (q_ovf_ff || res_sum[48:32] != '0) ? 32'hFFFF_FFFF : res_sum[31:0];
            dstage_ff <= 2'd3;
         end else if (cmd.op == ptba_pkg::OP_PCT_START) begin
            dstage_ff <= (total_ff == 32'd0) ? 2'd3 : 2'd2;
         end
         if (cmd.op == ptba_pkg::OP_BW_FINISH) begin
            if (cmd.sel_total) begin
               total_ff <= (33'(bw_ff) + 33'(dma_ff) > 33'h0_FFFF_FFFF) ? 32'hFFFF_FFFF
                           : bw_ff + dma_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == ptba_pkg::OP_REP_SUM) snap_ff[pidx] <= miss_ff[pidx];
      if (cmd.op == ptba_pkg::OP_EMIT) begin
         o_index <= 4'(ptr_ff);
         o_task  <= owner_ff[pidx];
         o_miss  <= snap_ff[pidx];
         o_bw    <= bw_ff;
         o_pct   <= (total_ff == 32'd0) ? 7'd0 : div_q[6:0];
         o_total <= total_ff;
      end
      if (cmd.op == ptba_pkg::OP_SLOT_LOAD) cur_miss_ff <= snap_ff[pidx];
   end
endmodule

>>> src/ptba_ctrl.sv
// ----------------------------------------------------------------------------
// ptba_ctrl
// Sequencer for tick updates and the report walk.
// ----------------------------------------------------------------------------
module ptba_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [1:0]         req_type,
   input  ptba_pkg::sts_type  sts,
   output ptba_pkg::cmd_type  cmd,
   output logic               out_load,
   output logic               out_last,
   input  logic               out_free
);
   typedef enum logic [3:0] {
      S_IDLE, S_SEARCH, S_APPLY, S_RSUM, S_TBW, S_TWAIT, S_TFIN,
      S_SBW0, S_SBW, S_SWAIT, S_PCT, S_PWAIT, S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      kind_report;

   assign req_tready = (state_ff == S_IDLE);
   assign kind_report = req_type == ptba_pkg::REQ_REPORT;

   always_comb begin
      state_in = state_ff;
      cmd = '{op: ptba_pkg::OP_NONE, sel_total: 1'b0, rst_slot: 1'b0, nxt_slot: 1'b0};
      out_load = 1'b0;
      out_last = sts.slot_last;
      unique case (state_ff)
         S_IDLE: if (req_tvalid) begin
            if (req_type == ptba_pkg::REQ_TICK0 || req_type == ptba_pkg::REQ_TICK1) begin
               cmd.op = ptba_pkg::OP_TICK_LOAD; cmd.rst_slot = 1'b1; state_in = S_SEARCH;
            end else if (kind_report) begin
               cmd.op = ptba_pkg::OP_TICK_LOAD; cmd.rst_slot = 1'b1; state_in = S_RSUM;
            end
         end
         S_SEARCH: if (sts.found || sts.search_end) state_in = S_APPLY;
            else begin
               cmd.op = ptba_pkg::OP_SEARCH; cmd.nxt_slot = 1'b1;
            end
         S_APPLY: begin cmd.op = ptba_pkg::OP_TICK_APPLY; state_in = S_IDLE; end
         S_RSUM: if (sts.search_end) begin
               cmd.rst_slot = 1'b1;
               state_in = (sts.ticks_zero || !sts.have_slots) ? S_IDLE : S_TBW;
            end else begin
               cmd.op = ptba_pkg::OP_REP_SUM; cmd.nxt_slot = 1'b1;
            end
         S_TBW: begin
            cmd.op = ptba_pkg::OP_BW_START; cmd.sel_total = 1'b1; state_in = S_TWAIT;
         end
         S_TWAIT: if (sts.div_done) state_in = S_TFIN;
         S_TFIN: begin
            cmd.op = ptba_pkg::OP_BW_FINISH; cmd.sel_total = 1'b1; state_in = S_SBW0;
         end
         S_SBW0: begin   // loads slot operand
            cmd.op = ptba_pkg::OP_SLOT_LOAD; state_in = S_SBW;
         end
         S_SBW: begin cmd.op = ptba_pkg::OP_BW_START; state_in = S_SWAIT; end
         S_SWAIT: if (sts.div_done) state_in = S_PCT;
         S_PCT: begin cmd.op = ptba_pkg::OP_PCT_START; state_in = S_PWAIT; end
         S_PWAIT: if (sts.div_done) state_in = S_EMIT;
         S_EMIT: if (out_free) begin
            cmd.op = ptba_pkg::OP_EMIT; out_load = 1'b1;
            if (sts.slot_last) state_in = S_IDLE;
            else begin cmd.nxt_slot = 1'b1; state_in = S_SBW0; end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule

>>> src/per_task_bandwidth_accounting_core.sv
// ----------------------------------------------------------------------------
// per_task_bandwidth_accounting_core
// Per-task miss-traffic monitor with bandwidth report.
//
// Usage: req_ carries ticks (cpu0/cpu1) and report requests; rsp_ carries one
// transfer per used slot on a report with a nonzero tick count, tlast on the
// final one. csr_ writes the tick rate, line size and DMA bandwidth; the user
// must write them only while idle, as the block does not enforce it. A tick
// does a serial slot search. A report makes a sum pass over the slots, then
// computes the total bandwidth, then per slot runs two bandwidth divisions
// and one percent division on one shared radix-2 divider.
// Reset clears the miss counters, last counter values, tick count and slot
// usage and sets the CSR registers to their defaults. A stalled rsp_ holds
// the walk at the next result; req_ is refused until the current item is done.
// ----------------------------------------------------------------------------
module per_task_bandwidth_accounting_core #(
   parameter int TABLE_SLOTS = ptba_pkg::TableSlotsDefault
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [1:0]    req_tuser,   // req_type
   input  logic [47:0]   req_tdata,   // task_id[15:0], counter_value[47:16]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [127:0]  rsp_tdata,   // slot_index, slot_task, miss_total,
                                      // task_bandwidth, share_percent,
                                      // total_bandwidth, zero pad
   output logic          rsp_tlast,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [31:0]   csr_wdata
);
   ptba_pkg::cmd_type cmd;
   ptba_pkg::sts_type sts;
   logic        out_load, out_last, valid_ff, last_ff;
   logic [3:0]  o_index;
   logic [15:0] o_task;
   logic [31:0] o_miss, o_bw, o_total;
   logic [6:0]  o_pct;

   ptba_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .req_type(req_tuser),
      .sts, .cmd, .out_load, .out_last, .out_free(!valid_ff || rsp_tready));

   ptba_datapath #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
      .clock, .reset, .cmd, .sts, .req_type(req_tuser),
      .task_id(req_tdata[15:0]), .counter_value(req_tdata[47:16]),
      .csr_we, .csr_index, .csr_wdata,
      .o_index, .o_task, .o_miss, .o_bw, .o_pct, .o_total);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (out_load) valid_ff <= 1'b1;
      else if (rsp_tready) valid_ff <= 1'b0;
      if (out_load) last_ff <= out_last;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {5'd0, o_total, o_pct, o_bw, o_miss, o_task, o_index};

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      out_load |-> !req_tready) else $error("result load while accepting");
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> o_pct <= 7'd100) else $error("percent out of range");
endmodule

>>> tb/per_task_bandwidth_accounting_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_task_bandwidth_accounting_core_test
// Drives tick and report transfers into the per-task bandwidth accounting
// core and checks every report transfer against a cycle-free model of the
// slot table, the period tick count and the bandwidth arithmetic. A short
// directed table comes first, then random phases with fresh register
// settings, random stalls on both sides and a quiet tail with no idling.
// ----------------------------------------------------------------------------
module per_task_bandwidth_accounting_core_test;

   localparam int SLOTS     = 16;
   localparam int PHASES    = 12;
   localparam int PER_PHASE = 37;
   localparam int SETTLE    = 400;
   localparam int LIMIT     = 10000000;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [3:0]  idx;
      logic [15:0] owner;
      logic [31:0] misses;
      logic [31:0] bw;
      logic [6:0]  pct;
      logic [31:0] total;
      logic        last;
   } slot_report_type;

   typedef struct {
      logic [1:0]      kind;
      logic [15:0]     task_id;
      logic [31:0]     counter;
      bit              typed;
      slot_report_type typed_rep;
   } stim_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [1:0]    req_tuser = '0;
   logic [47:0]   req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [127:0]  rsp_tdata;
   logic          rsp_tlast;
   logic          csr_we = 1'b0;
   logic [1:0]    csr_index = '0;
   logic [31:0]   csr_wdata = '0;

   per_task_bandwidth_accounting_core dut (.*);

   // Model state.
   logic [16:0]   m_rate;
   logic [12:0]   m_line;
   logic [31:0]   m_dma;
   logic [31:0]   m_last_cnt [2];
   logic [15:0]   m_owner [SLOTS];
   logic [31:0]   m_misses [SLOTS];
   int            m_used;
   logic [31:0]   m_ticks;

   slot_report_type pending_reports [$];
   int            errors = 0;
   int            cycles = 0;
   bit            quiet = 1'b0;
   int            rsp_stall = 0;
   logic [15:0]   task_pool [20];

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("FAIL per_task_bandwidth_accounting_core");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic logic [31:0] scaled_bandwidth(input logic [63:0] m,
                                                    input logic [31:0] ticks);
      logic [63:0] num, q, r, res;
      if ({32'd0, ticks} * 100 <= {47'd0, m_rate}) return '0;
      num = m * m_line;
      q = num / ticks;
      r = num % ticks;
      if (q > 64'hFFFF_FFFF) return '1;
      res = q * m_rate + (r * m_rate) / ticks;
      return (res > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : res[31:0];
   endfunction

   // Applies one accepted request to the model, queueing any report results.
   task automatic account_request(input logic [1:0] kind, input logic [15:0] tid,
                                  input logic [31:0] cnt);
      logic [31:0] delta, ticks;
      logic [31:0] snap [SLOTS];
      logic [63:0] sum, total, pct;
      slot_report_type rep;
      int hit;
      hit = -1;
      sum = '0;
      if (kind == ptba_pkg::REQ_TICK0 || kind == ptba_pkg::REQ_TICK1) begin
         delta = cnt - m_last_cnt[kind[0]];
         m_last_cnt[kind[0]] = cnt;
         for (int i = 0; i < m_used; i++)
            if (hit < 0 && m_owner[i] == tid) hit = i;
         if (hit < 0 && m_used < SLOTS) begin
            hit = m_used;
            m_owner[hit] = tid;
            m_misses[hit] = '0;
            m_used++;
         end
         if (hit >= 0) m_misses[hit] += delta;
         if (kind == ptba_pkg::REQ_TICK0) m_ticks++;
      end else if (kind == ptba_pkg::REQ_REPORT) begin
         ticks = m_ticks;
         for (int i = 0; i < m_used; i++) begin
            snap[i] = m_misses[i];
            m_misses[i] = '0;
            sum += snap[i];
         end
         m_ticks = '0;
         if (ticks != 0) begin
            total = scaled_bandwidth(sum, ticks) + m_dma;
            if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
            for (int i = 0; i < m_used; i++) begin
               rep.idx    = i[3:0];
               rep.owner  = m_owner[i];
               rep.misses = snap[i];
               rep.bw     = scaled_bandwidth(snap[i], ticks);
               pct = (total != 0) ? ({32'd0, rep.bw} * 100) / total : '0;
               rep.pct    = pct[6:0];
               rep.total  = total[31:0];
               rep.last   = (i == m_used - 1);
               pending_reports.push_back(rep);
            end
         end
      end
   endtask

   task automatic send_request(input logic [1:0] kind, input logic [15:0] tid,
                               input logic [31:0] cnt);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {cnt, tid};
      do @(posedge clock); while (!req_tready);
      account_request(kind, tid, cnt);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         ptba_pkg::CSR_TICK_RATE: m_rate = value[16:0];
         ptba_pkg::CSR_LINE:      m_line = value[12:0];
         ptba_pkg::CSR_DMA:       m_dma  = value;
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Result channel: random stall bursts, none in the quiet tail.
   always @(posedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall  <= rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_stall  <= $urandom_range(0, 14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      slot_report_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[3:0], rsp_tdata[19:4], rsp_tdata[51:20], rsp_tdata[83:52],
                rsp_tdata[90:84], rsp_tdata[122:91], rsp_tlast};
         if (pending_reports.size() == 0) begin
            report_mismatch($sformatf("unexpected result slot %0d", got.idx));
         end else begin
            want = pending_reports.pop_front();
            if (got.idx !== want.idx)
               report_mismatch($sformatf("slot_index %0d, want %0d", got.idx, want.idx));
            if (got.owner !== want.owner)
               report_mismatch($sformatf("slot_task %h, want %h", got.owner, want.owner));
            if (got.misses !== want.misses)
               report_mismatch($sformatf("miss_total %h, want %h", got.misses, want.misses));
            if (got.bw !== want.bw)
               report_mismatch($sformatf("task_bandwidth %h, want %h", got.bw, want.bw));
            if (got.pct !== want.pct)
               report_mismatch($sformatf("share_percent %0d, want %0d", got.pct, want.pct));
            if (got.total !== want.total)
               report_mismatch($sformatf("total_bandwidth %h, want %h", got.total, want.total));
            if (got.last !== want.last)
               report_mismatch($sformatf("tlast %b, want %b", got.last, want.last));
         end
      end
   end

   initial begin
      stim_row_type rows [$];
      stim_row_type row;
      logic [1:0] kind;
      logic [31:0] cnt;
      int pick;

      m_rate = ptba_pkg::TickRateReset;
      m_line = ptba_pkg::LineReset;
      m_dma  = ptba_pkg::DmaReset;
      m_last_cnt = '{default: '0};
      m_owner = '{default: '0};
      m_misses = '{default: '0};
      m_used = 0;
      m_ticks = '0;
      foreach (task_pool[i]) task_pool[i] = 16'($urandom_range(0, 16'hFFFF));

      // Report before any tick, then a single-tick period whose bandwidth is
      // zero because one tick is below the rate threshold.
      rows.push_back('{ptba_pkg::REQ_REPORT, 16'h0000, 32'h0, 1'b0, '0});
      rows.push_back('{ptba_pkg::REQ_TICK0, 16'h0000, 32'd1000, 1'b0, '0});
      rows.push_back('{ptba_pkg::REQ_REPORT, 16'h0000, 32'h0, 1'b1,
                       '{4'd0, 16'h0000, 32'd1000, 32'd0, 7'd0, 32'd165888000, 1'b1}});
      // Counter wrap on cpu1, an all-ones task id, and the unused code.
      rows.push_back('{ptba_pkg::REQ_TICK1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, '0});
      rows.push_back('{ptba_pkg::REQ_TICK1, 16'hFFFF, 32'h0000_0005, 1'b0, '0});
      rows.push_back('{ptba_pkg::REQ_TICK0, 16'h1234, 32'hFFFF_FFFF, 1'b0, '0});
      rows.push_back('{REQ_UNUSED, 16'hABCD, 32'd77, 1'b0, '0});
      rows.push_back('{ptba_pkg::REQ_REPORT, 16'h0000, 32'h0, 1'b0, '0});
      for (int i = 0; i < 14; i++)
         rows.push_back('{ptba_pkg::REQ_TICK0, (i % 2) ? 16'h0000 : 16'hFFFF,
                          32'd100 * (i + 1), 1'b0, '0});
      rows.push_back('{ptba_pkg::REQ_TICK1, 16'h1234, 32'h8000_0000, 1'b0, '0});
      rows.push_back('{ptba_pkg::REQ_REPORT, 16'h0000, 32'h0, 1'b0, '0});

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         row = rows[i];
         if (row.typed) begin
            // The typed row's expectation replaces the model's for this report.
            send_request(row.kind, row.task_id, row.counter);
            if (pending_reports.size() > 0) void'(pending_reports.pop_back());
            pending_reports.push_back(row.typed_rep);
         end else begin
            send_request(row.kind, row.task_id, row.counter);
         end
      end

      for (int ph = 1; ph <= PHASES; ph++) begin
         wait_drained();
         quiet = (ph > PHASES - 3);
         case (ph)
            1: begin
               write_csr(ptba_pkg::CSR_TICK_RATE, 32'd1);
               write_csr(ptba_pkg::CSR_LINE, 32'd1);
               write_csr(ptba_pkg::CSR_DMA, 32'd0);
            end
            2: begin
               write_csr(ptba_pkg::CSR_TICK_RATE, 32'd100000);
               write_csr(ptba_pkg::CSR_LINE, 32'd4096);
               write_csr(ptba_pkg::CSR_DMA, 32'hFFFF_FFFF);
            end
            3: begin
               write_csr(ptba_pkg::CSR_TICK_RATE, 32'd0);
               write_csr(ptba_pkg::CSR_LINE, 32'd0);
               write_csr(ptba_pkg::CSR_DMA, $urandom);
            end
            4: begin
               write_csr(ptba_pkg::CSR_TICK_RATE, 32'h1FFFF);
               write_csr(ptba_pkg::CSR_LINE, 32'h1FFF);
               write_csr(ptba_pkg::CSR_DMA, 32'd0);
            end
            default: begin
               write_csr(ptba_pkg::CSR_TICK_RATE, $urandom_range(1, 300));
               write_csr(ptba_pkg::CSR_LINE, $urandom_range(1, 8191));
               write_csr(ptba_pkg::CSR_DMA, $urandom_range(0, 3) == 0 ? $urandom
                                                           : $urandom_range(0, 5000));
            end
         endcase
         csr_we <= 1'b0;

         for (int n = 0; n < PER_PHASE; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 7)       kind = ptba_pkg::REQ_REPORT;
            else if (pick < 9)  kind = REQ_UNUSED;
            else if (pick < 40) kind = ptba_pkg::REQ_TICK1;
            else                kind = ptba_pkg::REQ_TICK0;
            cnt = m_last_cnt[kind[0]];
            pick = $urandom_range(0, 99);
            if (pick < 80)      cnt = cnt + $urandom_range(0, 5000);
            else if (pick < 92) cnt = $urandom;
            else                cnt = cnt - $urandom_range(1, 3);
            send_request(kind, task_pool[$urandom_range(0, 19)], cnt);
         end
         if (ph == PHASES) send_request(ptba_pkg::REQ_REPORT, 16'h0, 32'h0);
      end

      wait_drained();
      if (errors == 0) begin
         $display("PASS per_task_bandwidth_accounting_core");
      end else begin
         $display("FAIL per_task_bandwidth_accounting_core");
      end
      $finish;
   end

endmodule

>>> per_task_bandwidth_accounting_core.f
src/ptba_pkg.sv
src/ptba_div.sv
src/ptba_datapath.sv
src/ptba_ctrl.sv
src/per_task_bandwidth_accounting_core.sv
tb/per_task_bandwidth_accounting_core_test.sv
